// File: hw/rtl/hcsp_pkg.sv
// Package for the hex color string parser: phase type, character helpers, constants.
package hcsp_pkg;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_ZERO  = 3'd1,
    PH_CORE  = 3'd2,
    PH_TRAIL = 3'd3
  } phase_t;

  localparam logic [7:0]  CH_HASH  = 8'h23;
  localparam logic [7:0]  CH_ZERO  = 8'h30;
  localparam logic [7:0]  CH_LOW_X = 8'h78;
  localparam logic [7:0]  CH_UP_X  = 8'h58;
  localparam logic [3:0]  CNT_MAX  = 4'd9;
  localparam logic [31:0] COLOR_WHITE = 32'hFFFF_FFFF;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0D) || (c == 8'h0A);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]}) || (c inside {[8'h61:8'h66]}) ||
           (c inside {[8'h41:8'h46]});
  endfunction

  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [3:0] v;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else begin
      v = 4'(c[2:0] + 3'd1) + 4'd8;
    end
    return v;
  endfunction

  function automatic logic [3:0] sat_inc(input logic [3:0] n);
    return (n < CNT_MAX) ? n + 4'd1 : n;
  endfunction

endpackage

// File: hw/rtl/hex_color_string_parser_core.sv
// Hex color string parser: per-character parse state and color result register.
// A result is registered into the output register when its last character leaves the input stage.
// Throughput: one character per cycle, except that a last character stalls until the result register is free.
// The input stage holds one request; a last character waits there while a result is pending.
// Reset (synchronous, rst_n low): parse state cleared, stored color set to opaque white.
module hex_color_string_parser_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_has_char,
  input  logic [7:0] in_char_code,
  input  logic       in_is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_ok,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha
);

  logic                s1_valid_r;
  logic                s1_has_r;
  logic [7:0]          s1_char_r;
  logic                s1_last_r;

  hcsp_pkg::phase_t    phase_r, phase_nxt;
  logic [31:0]         buf_r, buf_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  logic                err_r, err_nxt;
  logic [31:0]         color_r, color_nxt;

  logic                out_valid_r;
  logic                out_ok_r, ok_nxt;
  logic [31:0]         out_color_r;

  logic                out_free;
  logic                s1_adv;

  hcsp_pkg::phase_t    ph;
  logic [31:0]         dbuf;
  logic [3:0]          dcnt;
  logic                derr;
  logic                push0;
  logic                core;

  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    ph    = phase_r;
    dbuf  = buf_r;
    dcnt  = cnt_r;
    derr  = err_r;
    push0 = 1'b0;
    core  = 1'b0;
    if (s1_has_r) begin
      case (phase_r)
        hcsp_pkg::PH_LEAD: begin
          if (!hcsp_pkg::is_space(s1_char_r)) begin
            if (s1_char_r == hcsp_pkg::CH_HASH) begin
              ph = hcsp_pkg::PH_CORE;
            end else if (s1_char_r == hcsp_pkg::CH_ZERO) begin
              ph = hcsp_pkg::PH_ZERO;
            end else begin
              ph   = hcsp_pkg::PH_CORE;
              core = 1'b1;
            end
          end
        end
        hcsp_pkg::PH_ZERO: begin
          ph = hcsp_pkg::PH_CORE;
          if (s1_char_r != hcsp_pkg::CH_LOW_X && s1_char_r != hcsp_pkg::CH_UP_X) begin
            push0 = 1'b1;
            core  = 1'b1;
          end
        end
        hcsp_pkg::PH_CORE: begin
          core = 1'b1;
        end
        default: begin
          if (!hcsp_pkg::is_space(s1_char_r)) derr = 1'b1;
        end
      endcase
    end
    if (push0) begin
      dbuf = {dbuf[27:0], 4'h0};
      dcnt = hcsp_pkg::sat_inc(dcnt);
    end
    if (core) begin
      if (hcsp_pkg::is_space(s1_char_r)) begin
        ph = hcsp_pkg::PH_TRAIL;
      end else if (hcsp_pkg::is_hex(s1_char_r)) begin
        dbuf = {dbuf[27:0], hcsp_pkg::nibble_of(s1_char_r)};
        dcnt = hcsp_pkg::sat_inc(dcnt);
      end else begin
        derr = 1'b1;
      end
    end

    phase_nxt = ph;
    buf_nxt   = dbuf;
    cnt_nxt   = dcnt;
    err_nxt   = derr;
    color_nxt = color_r;
    ok_nxt    = 1'b0;

    if (s1_last_r) begin
      if (ph == hcsp_pkg::PH_ZERO) begin
        dbuf = {dbuf[27:0], 4'h0};
        dcnt = hcsp_pkg::sat_inc(dcnt);
      end
      if (!derr) begin
        case (dcnt)
          4'd3: begin
            ok_nxt    = 1'b1;
            color_nxt = {{2{dbuf[11:8]}}, {2{dbuf[7:4]}}, {2{dbuf[3:0]}}, 8'hFF};
          end
          4'd4: begin
            ok_nxt    = 1'b1;
            color_nxt = {{2{dbuf[15:12]}}, {2{dbuf[11:8]}}, {2{dbuf[7:4]}},
                         {2{dbuf[3:0]}}};
          end
          4'd6: begin
            ok_nxt    = 1'b1;
            color_nxt = {dbuf[23:0], 8'hFF};
          end
          4'd8: begin
            ok_nxt    = 1'b1;
            color_nxt = dbuf;
          end
          default: begin
            ok_nxt = 1'b0;
          end
        endcase
      end
      phase_nxt = hcsp_pkg::PH_LEAD;
      buf_nxt   = '0;
      cnt_nxt   = '0;
      err_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_has_r  <= in_has_char;
      s1_char_r <= in_char_code;
      s1_last_r <= in_is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hcsp_pkg::PH_LEAD;
      buf_r   <= '0;
      cnt_r   <= '0;
      err_r   <= 1'b0;
      color_r <= hcsp_pkg::COLOR_WHITE;
    end else if (s1_adv) begin
      phase_r <= phase_nxt;
      buf_r   <= buf_nxt;
      cnt_r   <= cnt_nxt;
      err_r   <= err_nxt;
      color_r <= color_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_ok_r    <= ok_nxt;
      out_color_r <= color_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_ok    = out_ok_r;
  assign out_red   = out_color_r[31:24];
  assign out_green = out_color_r[23:16];
  assign out_blue  = out_color_r[15:8];
  assign out_alpha = out_color_r[7:0];

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= hcsp_pkg::CNT_MAX)
    else $error("digit count above saturation");

  a_ok_matches_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_color_r == color_r)
    else $error("reported color differs from stored color");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> phase_r == hcsp_pkg::PH_LEAD && cnt_r == 4'd0 && !err_r)
    else $error("parse state not cleared after last character");

  a_color_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_adv && s1_last_r) |=> $stable(color_r))
    else $error("stored color changed without a finished string");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && !(s1_adv && s1_last_r) |=> !out_valid_r)
    else $error("result appeared without a last character");
`endif

endmodule

// File: sim/hex_color_string_parser_core_test.sv
// Testbench for hex_color_string_parser_core: character stream in, parsed color checked out.
`timescale 1ns / 1ps

module hex_color_string_parser_core_test;

  localparam int         ITEM_TARGET = 1900;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         MAX_PRINTS  = 40;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_LF       = 8'h0A;

  typedef struct packed {
    logic       has_char;
    logic [7:0] code;
    logic       is_last;
  } char_req_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } color_res_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_has_char = 1'b0;
  logic [7:0] in_char_code = 8'h00;
  logic       in_is_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_ok;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;

  char_req_t  pending_chars[$];
  color_res_t expected_colors[$];
  logic [7:0] str_buf[$];
  int         counted_items = 0;
  int         req_total = 0;
  int         accepted = 0;
  int         errors = 0;
  int         cycles = 0;

  // predictor state
  hcsp_pkg::phase_t pr_phase = hcsp_pkg::PH_LEAD;
  logic [31:0]      pr_digits = '0;
  logic [3:0]       pr_count = '0;
  logic             pr_bad = 1'b0;
  logic [31:0]      pr_color = hcsp_pkg::COLOR_WHITE;

  hex_color_string_parser_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_has_char  (in_has_char),
    .in_char_code (in_char_code),
    .in_is_last   (in_is_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_ok       (out_ok),
    .out_red      (out_red),
    .out_green    (out_green),
    .out_blue     (out_blue),
    .out_alpha    (out_alpha)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic blank(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  // bit 4 set: not a hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
    return 5'd16;
  endfunction

  task automatic push_nibble(input logic [3:0] v);
    pr_digits = {pr_digits[27:0], v};
    if (pr_count < hcsp_pkg::CNT_MAX) pr_count = pr_count + 4'd1;
  endtask

  task automatic core_char(input logic [7:0] c);
    logic [4:0] n;
    n = hex_nibble(c);
    if (blank(c)) begin
      pr_phase = hcsp_pkg::PH_TRAIL;
    end else if (!n[4]) begin
      push_nibble(n[3:0]);
    end else begin
      pr_bad = 1'b1;
    end
  endtask

  task automatic parse_char(input logic [7:0] c);
    case (pr_phase)
      hcsp_pkg::PH_LEAD: begin
        if (!blank(c)) begin
          if (c == hcsp_pkg::CH_HASH) begin
            pr_phase = hcsp_pkg::PH_CORE;
          end else if (c == hcsp_pkg::CH_ZERO) begin
            pr_phase = hcsp_pkg::PH_ZERO;
          end else begin
            pr_phase = hcsp_pkg::PH_CORE;
            core_char(c);
          end
        end
      end
      hcsp_pkg::PH_ZERO: begin
        pr_phase = hcsp_pkg::PH_CORE;
        if (c != hcsp_pkg::CH_LOW_X && c != hcsp_pkg::CH_UP_X) begin
          push_nibble(4'd0);
          core_char(c);
        end
      end
      hcsp_pkg::PH_CORE: core_char(c);
      default: begin
        if (!blank(c)) pr_bad = 1'b1;
      end
    endcase
  endtask

  task automatic close_string();
    logic [31:0] b;
    logic        ok;
    if (pr_phase == hcsp_pkg::PH_ZERO) push_nibble(4'd0);
    b = pr_digits;
    ok = 1'b0;
    if (!pr_bad) begin
      case (pr_count)
        4'd3: begin
          pr_color = {b[11:8], b[11:8], b[7:4], b[7:4], b[3:0], b[3:0], 8'hFF};
          ok = 1'b1;
        end
        4'd4: begin
          pr_color = {b[15:12], b[15:12], b[11:8], b[11:8],
                      b[7:4], b[7:4], b[3:0], b[3:0]};
          ok = 1'b1;
        end
        4'd6: begin
          pr_color = {b[23:0], 8'hFF};
          ok = 1'b1;
        end
        4'd8: begin
          pr_color = b;
          ok = 1'b1;
        end
        default: ok = 1'b0;
      endcase
    end
    expected_colors.push_back({ok, pr_color});
    pr_phase = hcsp_pkg::PH_LEAD;
    pr_digits = '0;
    pr_count = '0;
    pr_bad = 1'b0;
  endtask

  task automatic predict_request(input char_req_t r);
    if (r.has_char) parse_char(r.code);
    if (r.is_last) close_string();
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (errors < MAX_PRINTS)
      $display("mismatch %0s: got %02h expected %02h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // stimulus helpers
  task automatic add_req(input logic h, input logic [7:0] c, input logic l);
    pending_chars.push_back('{h, c, l});
    if (h || l) counted_items++;
  endtask

  task automatic add_string(input logic tail_empty);
    if (str_buf.size() == 0) begin
      add_req(1'b0, 8'($urandom), 1'b1);
    end else begin
      foreach (str_buf[i]) begin
        if ($urandom_range(19) == 0) add_req(1'b0, 8'($urandom), 1'b0);
        add_req(1'b1, str_buf[i], (i == str_buf.size() - 1) && !tail_empty);
      end
      if (tail_empty) add_req(1'b0, 8'($urandom), 1'b1);
    end
  endtask

  task automatic load_text(input string t);
    str_buf = {};
    for (int i = 0; i < t.len(); i++) str_buf.push_back(t[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic up);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (up ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] ws_char();
    case ($urandom_range(3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_CR;
      default: return CH_LF;
    endcase
  endfunction

  function automatic logic [7:0] odd_char();
    case ($urandom_range(5))
      0: return hcsp_pkg::CH_HASH;
      1: return hcsp_pkg::CH_ZERO;
      2: return hcsp_pkg::CH_LOW_X;
      3: return ws_char();
      4: return hex_char(4'($urandom), 1'($urandom));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic build_color_text(input logic broken);
    int n;
    int pos;
    str_buf = {};
    repeat ($urandom_range(2)) str_buf.push_back(ws_char());
    case ($urandom_range(3))
      1: str_buf.push_back(hcsp_pkg::CH_HASH);
      2: begin
        str_buf.push_back(hcsp_pkg::CH_ZERO);
        str_buf.push_back(hcsp_pkg::CH_LOW_X);
      end
      3: begin
        str_buf.push_back(hcsp_pkg::CH_ZERO);
        str_buf.push_back(hcsp_pkg::CH_UP_X);
      end
      default: ;
    endcase
    if ($urandom_range(9) < 2) begin
      case ($urandom_range(7))
        0: n = 0;
        1: n = 1;
        2: n = 2;
        3: n = 5;
        4: n = 7;
        5: n = 9;
        6: n = 10;
        default: n = 12;
      endcase
    end else begin
      case ($urandom_range(3))
        0: n = 3;
        1: n = 4;
        2: n = 6;
        default: n = 8;
      endcase
    end
    repeat (n) str_buf.push_back(hex_char(4'($urandom), 1'($urandom)));
    repeat ($urandom_range(2)) str_buf.push_back(ws_char());
    if (broken && str_buf.size() > 0) begin
      pos = $urandom_range(str_buf.size() - 1);
      str_buf[pos] = odd_char();
    end
  endtask

  function automatic int idle_pct(input logic sender);
    if (accepted < req_total / 3) return sender ? 21 : 68;
    if (accepted < 2 * req_total / 3) return sender ? 68 : 21;
    return 0;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_request('{in_has_char, in_char_code, in_is_last});
        accepted++;
      end
      if (!in_valid || in_ready) begin
        if (pending_chars.size() != 0 && $urandom_range(99) >= idle_pct(1'b1)) begin
          in_has_char <= pending_chars[0].has_char;
          in_char_code <= pending_chars[0].code;
          in_is_last <= pending_chars[0].is_last;
          in_valid <= 1'b1;
          void'(pending_chars.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_colors.size() == 0) begin
          report_mismatch("unexpected result", out_red, 8'h00);
        end else begin
          if (out_ok !== expected_colors[0].ok)
            report_mismatch("ok", 8'(out_ok), 8'(expected_colors[0].ok));
          if (out_red !== expected_colors[0].red)
            report_mismatch("red", out_red, expected_colors[0].red);
          if (out_green !== expected_colors[0].green)
            report_mismatch("green", out_green, expected_colors[0].green);
          if (out_blue !== expected_colors[0].blue)
            report_mismatch("blue", out_blue, expected_colors[0].blue);
          if (out_alpha !== expected_colors[0].alpha)
            report_mismatch("alpha", out_alpha, expected_colors[0].alpha);
          void'(expected_colors.pop_front());
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct(1'b0));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    // directed strings
    str_buf = {};
    add_string(1'b0);
    load_text("0");
    add_string(1'b0);
    load_text("0X");
    add_string(1'b0);
    load_text("#");
    add_req(1'b1, str_buf[0], 1'b0);
    add_req(1'b0, 8'hFF, 1'b0);
    add_req(1'b0, 8'h00, 1'b1);
    load_text(" #f0A8\t");
    add_string(1'b0);
    load_text("0xFf00Aa80");
    add_string(1'b0);
    load_text("abc z");
    add_string(1'b0);
    str_buf = {8'hFF};
    add_string(1'b0);
    str_buf = {8'h00};
    add_string(1'b1);
    // random strings: mostly well formed, some broken, some raw noise
    while (counted_items < ITEM_TARGET) begin
      case ($urandom_range(9))
        0: begin
          str_buf = {};
          repeat ($urandom_range(8)) str_buf.push_back(odd_char());
        end
        1, 2: build_color_text(1'b1);
        default: build_color_text(1'b0);
      endcase
      add_string($urandom_range(7) == 0);
    end
    req_total = pending_chars.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_chars.size() != 0 || in_valid || expected_colors.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/hcsp_pkg.sv
hw/rtl/hex_color_string_parser_core.sv
sim/hex_color_string_parser_core_test.sv
